/* rtl/lmrs_pkg.sv */
// ----------------------------------------------------------------------------
// Lateral steering Riccati core package
// Types, scratch memory map and the microprogram of the shared arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lmrs_pkg;

	localparam int ADDR_W = 6;
	localparam int RAM_DEPTH = 64;
	localparam int PC_W = 7;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [PC_W-1:0] pc_t;
	typedef logic [2:0] cfg_idx_t;

	localparam cfg_idx_t CFG_STEP_DISTANCE = 3'd0;
	localparam cfg_idx_t CFG_WHEELBASE = 3'd1;
	localparam cfg_idx_t CFG_FF_ENABLE = 3'd2;
	localparam cfg_idx_t CFG_W_CROSS = 3'd3;
	localparam cfg_idx_t CFG_W_HEADING = 3'd4;
	localparam cfg_idx_t CFG_W_STEER = 3'd5;
	localparam cfg_idx_t CFG_W_RATE = 3'd6;
	localparam cfg_idx_t CFG_HORIZON = 3'd7;

	typedef enum logic [2:0] {K_MAC, K_DIV, K_CHKG, K_LAST, K_LOOP, K_DONE} kind_t;

	typedef enum logic [3:0] {
		S_IDLE, S_INIT, S_DECODE, S_FETCH, S_MUL, S_SUM,
		S_DIV_SETUP, S_DIV_RUN, S_DIV_END, S_FINISH
	} state_t;

	typedef struct packed {
		kind_t kind;
		addr_t dst;
		addr_t a;
		addr_t b;
		addr_t e;
		addr_t f;
		logic  sh30;
		logic  use_acc;
		logic  no_fit;
		logic  wb_div;
	} uop_t;

	localparam addr_t A_ZERO = 6'd0;
	localparam addr_t A_ONE  = 6'd1;
	localparam addr_t A_MONE = 6'd2;
	localparam addr_t A_FOUR = 6'd3;
	localparam addr_t A_TWO  = 6'd4;
	localparam addr_t A_D    = 6'd5;
	localparam addr_t A_CURV = 6'd6;
	localparam addr_t A_Q00  = 6'd7;
	localparam addr_t A_Q11  = 6'd8;
	localparam addr_t A_Q22  = 6'd9;
	localparam addr_t A_R    = 6'd10;
	localparam addr_t A_CTE  = 6'd11;
	localparam addr_t A_HDG  = 6'd12;
	localparam addr_t A_PREV = 6'd13;
	localparam addr_t A_G    = 6'd14;
	localparam addr_t A_NG   = 6'd15;
	localparam addr_t A_C1   = 6'd16;
	localparam addr_t A_P00  = 6'd17;
	localparam addr_t A_P01  = 6'd18;
	localparam addr_t A_P02  = 6'd19;
	localparam addr_t A_P10  = 6'd20;
	localparam addr_t A_P11  = 6'd21;
	localparam addr_t A_P12  = 6'd22;
	localparam addr_t A_P20  = 6'd23;
	localparam addr_t A_P21  = 6'd24;
	localparam addr_t A_P22  = 6'd25;
	localparam addr_t A_S0   = 6'd26;
	localparam addr_t A_S1   = 6'd27;
	localparam addr_t A_S2   = 6'd28;
	localparam addr_t A_T1   = 6'd29;
	localparam addr_t A_T2   = 6'd30;
	localparam addr_t A_PB0  = 6'd31;
	localparam addr_t A_PB1  = 6'd32;
	localparam addr_t A_PB2  = 6'd33;
	localparam addr_t A_DBPB = 6'd34;
	localparam addr_t A_GG   = 6'd35;
	localparam addr_t A_PA0  = 6'd36;
	localparam addr_t A_PA1  = 6'd37;
	localparam addr_t A_PA2  = 6'd38;
	localparam addr_t A_BT0  = 6'd39;
	localparam addr_t A_BT1  = 6'd40;
	localparam addr_t A_K0   = 6'd41;
	localparam addr_t A_K1   = 6'd42;
	localparam addr_t A_K2   = 6'd43;
	localparam addr_t A_TMP  = 6'd44;
	localparam addr_t A_PC0  = 6'd45;
	localparam addr_t A_PC1  = 6'd46;
	localparam addr_t A_PC2  = 6'd47;
	localparam addr_t A_DBPC = 6'd48;
	localparam addr_t A_KFF  = 6'd49;
	localparam addr_t A_AT0  = 6'd50;
	localparam addr_t A_AT1  = 6'd51;
	localparam addr_t A_AT2  = 6'd52;
	localparam addr_t A_M    = 6'd54;
	localparam addr_t A_DEL  = 6'd55;
	localparam addr_t A_CMD  = 6'd56;

	localparam addr_t A_INIT_LAST = A_S2;

	localparam pc_t LOOP_PC = 7'd6;
	localparam pc_t FINAL_PC = 7'd58;

	function automatic uop_t mk(input kind_t k, input addr_t dst, input addr_t a,
		input addr_t b, input addr_t e, input addr_t f, input logic sh30,
		input logic use_acc, input logic no_fit, input logic wb_div);
		uop_t u;
		u.kind = k;
		u.dst = dst;
		u.a = a;
		u.b = b;
		u.e = e;
		u.f = f;
		u.sh30 = sh30;
		u.use_acc = use_acc;
		u.no_fit = no_fit;
		u.wb_div = wb_div;
		return u;
	endfunction

	function automatic uop_t mac(input addr_t dst, input addr_t a, input addr_t b,
		input addr_t e, input addr_t f);
		return mk(K_MAC, dst, a, b, e, f, 1'b0, 1'b0, 1'b0, 1'b0);
	endfunction

	function automatic uop_t dvq(input addr_t dst, input addr_t num, input addr_t den);
		return mk(K_DIV, dst, num, den, A_ZERO, A_ZERO, 1'b0, 1'b0, 1'b0, 1'b0);
	endfunction

	function automatic uop_t ctl(input kind_t k);
		return mk(k, A_ZERO, A_ZERO, A_ZERO, A_ZERO, A_ZERO, 1'b0, 1'b0, 1'b0, 1'b0);
	endfunction

	// Each multiply-add step computes dst = sat(round(a * b) + e + f); use_acc puts the accumulator in place of e.
	function automatic uop_t lmrs_uop(input pc_t pc);
		uop_t u;
		case (pc)
			7'd0:  u = mk(K_DIV, A_G, A_D, A_ZERO, A_ZERO, A_ZERO, 1'b0, 1'b0, 1'b0, 1'b1);
			7'd1:  u = mac(A_NG, A_G, A_MONE, A_ZERO, A_ZERO);
			7'd2:  u = mk(K_MAC, A_C1, A_D, A_CURV, A_ZERO, A_ZERO, 1'b1, 1'b0, 1'b0, 1'b0);
			7'd3:  u = mac(A_P00, A_Q00, A_FOUR, A_ZERO, A_ZERO);
			7'd4:  u = mac(A_P11, A_Q11, A_FOUR, A_ZERO, A_ZERO);
			7'd5:  u = mac(A_P22, A_Q22, A_TWO, A_ZERO, A_ZERO);
			7'd6:  u = mac(A_PB0, A_P01, A_NG, A_P02, A_ZERO);
			7'd7:  u = mac(A_PB1, A_P11, A_NG, A_P12, A_ZERO);
			7'd8:  u = mac(A_PB2, A_P21, A_NG, A_P22, A_ZERO);
			7'd9:  u = mac(A_DBPB, A_NG, A_PB1, A_PB2, A_ZERO);
			7'd10: u = mac(A_GG, A_R, A_ONE, A_DBPB, A_ZERO);
			7'd11: u = ctl(K_CHKG);
			7'd12: u = mac(A_PA0, A_P00, A_D, A_P01, A_ZERO);
			7'd13: u = mac(A_PA1, A_P10, A_D, A_P11, A_ZERO);
			7'd14: u = mac(A_PA2, A_P20, A_D, A_P21, A_ZERO);
			7'd15: u = mac(A_BT0, A_NG, A_P10, A_P20, A_ZERO);
			7'd16: u = mac(A_BT1, A_NG, A_PA1, A_PA2, A_ZERO);
			7'd17: u = dvq(A_K0, A_BT0, A_GG);
			7'd18: u = dvq(A_K1, A_BT1, A_GG);
			7'd19: u = dvq(A_K2, A_DBPB, A_GG);
			7'd20: u = mac(A_TMP, A_P01, A_C1, A_ZERO, A_ZERO);
			7'd21: u = mac(A_PC0, A_TMP, A_ONE, A_S0, A_ZERO);
			7'd22: u = mac(A_TMP, A_P11, A_C1, A_ZERO, A_ZERO);
			7'd23: u = mac(A_PC1, A_TMP, A_ONE, A_S1, A_ZERO);
			7'd24: u = mac(A_TMP, A_P21, A_C1, A_ZERO, A_ZERO);
			7'd25: u = mac(A_PC2, A_TMP, A_ONE, A_S2, A_ZERO);
			7'd26: u = mac(A_DBPC, A_NG, A_PC1, A_PC2, A_ZERO);
			7'd27: u = dvq(A_KFF, A_DBPC, A_GG);
			7'd28: u = ctl(K_LAST);
			7'd29: u = mac(A_AT0, A_D, A_P00, A_P10, A_ZERO);
			7'd30: u = mac(A_AT1, A_D, A_PA0, A_PA1, A_ZERO);
			7'd31: u = mac(A_AT2, A_D, A_PB0, A_PB1, A_ZERO);
			7'd32: u = mac(A_M, A_PB0, A_K0, A_ZERO, A_ZERO);
			7'd33: u = mac(A_P00, A_M, A_MONE, A_P00, A_Q00);
			7'd34: u = mac(A_M, A_PB0, A_K1, A_ZERO, A_ZERO);
			7'd35: u = mac(A_P01, A_M, A_MONE, A_PA0, A_ZERO);
			7'd36: u = mac(A_M, A_PB0, A_K2, A_ZERO, A_ZERO);
			7'd37: u = mac(A_P02, A_M, A_MONE, A_PB0, A_ZERO);
			7'd38: u = mac(A_M, A_AT2, A_K0, A_ZERO, A_ZERO);
			7'd39: u = mac(A_P10, A_M, A_MONE, A_AT0, A_ZERO);
			7'd40: u = mac(A_M, A_AT2, A_K1, A_ZERO, A_ZERO);
			7'd41: u = mac(A_P11, A_M, A_MONE, A_AT1, A_Q11);
			7'd42: u = mac(A_M, A_AT2, A_K2, A_ZERO, A_ZERO);
			7'd43: u = mac(A_P12, A_M, A_MONE, A_AT2, A_ZERO);
			7'd44: u = mac(A_M, A_DBPB, A_K0, A_ZERO, A_ZERO);
			7'd45: u = mac(A_P20, A_M, A_MONE, A_BT0, A_ZERO);
			7'd46: u = mac(A_M, A_DBPB, A_K1, A_ZERO, A_ZERO);
			7'd47: u = mac(A_P21, A_M, A_MONE, A_BT1, A_ZERO);
			7'd48: u = mac(A_M, A_DBPB, A_K2, A_ZERO, A_ZERO);
			7'd49: u = mac(A_P22, A_M, A_MONE, A_DBPB, A_Q22);
			7'd50: u = mac(A_M, A_PB0, A_KFF, A_ZERO, A_ZERO);
			7'd51: u = mac(A_S0, A_M, A_MONE, A_PC0, A_ZERO);
			7'd52: u = mac(A_M, A_PB1, A_KFF, A_ZERO, A_ZERO);
			7'd53: u = mac(A_T1, A_M, A_MONE, A_PC1, A_ZERO);
			7'd54: u = mac(A_M, A_PB2, A_KFF, A_ZERO, A_ZERO);
			7'd55: u = mac(A_T2, A_M, A_MONE, A_PC2, A_ZERO);
			7'd56: u = mac(A_S1, A_D, A_S0, A_T1, A_ZERO);
			7'd57: u = mk(K_LOOP, A_S2, A_NG, A_T1, A_T2, A_ZERO, 1'b0, 1'b0, 1'b0, 1'b0);
			7'd58: u = mk(K_MAC, A_ZERO, A_K0, A_CTE, A_ZERO, A_ZERO, 1'b0, 1'b0, 1'b1, 1'b0);
			7'd59: u = mk(K_MAC, A_ZERO, A_K1, A_HDG, A_ZERO, A_ZERO, 1'b0, 1'b1, 1'b1, 1'b0);
			7'd60: u = mk(K_MAC, A_TMP, A_K2, A_PREV, A_ZERO, A_ZERO, 1'b0, 1'b1, 1'b0, 1'b0);
			7'd61: u = mac(A_M, A_TMP, A_ONE, A_KFF, A_ZERO);
			7'd62: u = mac(A_DEL, A_M, A_MONE, A_ZERO, A_ZERO);
			7'd63: u = mac(A_CMD, A_PREV, A_ONE, A_DEL, A_ZERO);
			default: u = ctl(K_DONE);
		endcase
		return u;
	endfunction

	// Saturates to the signed 32-bit range; the top bit flags saturation.
	function automatic logic [32:0] fit32(input logic signed [63:0] x);
		logic [32:0] r;
		if (x > 64'sh0000_0000_7FFF_FFFF) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else if (x < 64'shFFFF_FFFF_8000_0000) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, x[31:0]};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/lateral_mpc_riccati_steering_core.sv */
// ----------------------------------------------------------------------------
// Lateral steering Riccati core
// Finite-horizon LQR steering: a backward Riccati recursion over a kinematic
// lateral error model, run as a microprogram on one shared multiply-add unit
// and one bit-serial divider over a scratch RAM.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// config    in         cfg_we                  cfg_index, cfg_data
// request   in         start while not busy    four error and steer fields
// result    out        done, one cycle         steer_change, steer_command, result_valid
//
// A request writes the scratch constants and inputs, runs the setup arithmetic,
// one pass per horizon step (shorter for the last one) and the closing steps.
// The multiply-add step reads its operands one by one on the single RAM read
// port, and a division runs bit-serially over a 32 + FRAC_BITS bit dividend.
// After reset the core is idle at once. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
`default_nettype none

module lateral_mpc_riccati_steering_core #(
	parameter int MAX_HORIZON = 64,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire lmrs_pkg::cfg_idx_t    cfg_index,
	input  wire logic [31:0]           cfg_data,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic signed [31:0]    cross_track_error,
	input  wire logic signed [31:0]    heading_error,
	input  wire logic signed [31:0]    path_curvature,
	input  wire logic signed [31:0]    previous_steer,
	output logic                       done,
	output logic signed [31:0]         steer_change,
	output logic signed [31:0]         steer_command,
	output logic                       result_valid
);

	import lmrs_pkg::*;

	localparam logic [31:0] ONE32 = 32'(1) << FRAC_BITS;
	localparam logic [31:0] MONE32 = 32'(0) - ONE32;
	localparam logic signed [63:0] HALF64 = 64'(1) << (FRAC_BITS - 1);
	localparam logic signed [63:0] HALF30 = 64'(1) << 29;
	localparam int WMIN_I = ((1 << FRAC_BITS) + 500) / 1000;
	localparam logic [31:0] WMIN = (WMIN_I < 1) ? 32'd1 : 32'(WMIN_I);
	localparam int NUMW = 32 + FRAC_BITS;
	localparam int DCW = $clog2(NUMW);
	localparam int HZW = ($clog2(MAX_HORIZON + 1) > 7) ? $clog2(MAX_HORIZON + 1) : 7;

	logic [31:0] step_distance_q, wheelbase_q, w_cross_q, w_heading_q, w_steer_q, w_rate_q;
	logic        ff_enable_q;
	logic [6:0]  horizon_q;

	state_t state_q, state_d;
	pc_t    pc_q;
	uop_t   uop_q, cur_uop;
	addr_t  init_q;
	logic [2:0] k_q;
	logic [HZW-1:0] step_q, hz_eff;
	logic [DCW-1:0] dcnt_q;
	logic   ok_q, sat_q;

	logic signed [31:0] cte_q, hdg_q, curv_q, prev_q;
	logic signed [31:0] opa_q, opb_q, ope_q, opf_q, last_q, del_q, cmd_q;
	logic signed [63:0] prod_q, acc_q;
	logic [NUMW-1:0] dvd_q;
	logic [31:0] rem_q, den_q;
	logic        neg_q;

	logic        ram_we;
	addr_t       ram_waddr, ram_raddr;
	logic [31:0] ram_wdata, ram_rdata, init_word, wb_eff;
	logic signed [63:0] rnd, e_term, sum;
	logic [32:0] sum_fit, div_fit;
	logic signed [63:0] q_signed;
	logic [32:0] trial;
	logic        trial_ge;
	logic [32:0] mag;
	logic [31:0] den_sel;

	lmrs_ram #(.WIDTH(32), .DEPTH(RAM_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_distance_q <= 32'd65536;
			wheelbase_q <= 32'd176947;
			ff_enable_q <= 1'b1;
			w_cross_q <= 32'd65536;
			w_heading_q <= 32'd65536;
			w_steer_q <= 32'd65536;
			w_rate_q <= 32'd65536;
			horizon_q <= 7'd10;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_STEP_DISTANCE: step_distance_q <= cfg_data;
				CFG_WHEELBASE: wheelbase_q <= cfg_data;
				CFG_FF_ENABLE: ff_enable_q <= cfg_data[0];
				CFG_W_CROSS: w_cross_q <= cfg_data;
				CFG_W_HEADING: w_heading_q <= cfg_data;
				CFG_W_STEER: w_steer_q <= cfg_data;
				CFG_W_RATE: w_rate_q <= cfg_data;
				CFG_HORIZON: horizon_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	assign cur_uop = lmrs_uop(pc_q);
	assign wb_eff = (wheelbase_q < WMIN) ? WMIN : wheelbase_q;

	always_comb begin
		if (horizon_q == 7'd0) begin
			hz_eff = HZW'(1);
		end else if (HZW'(horizon_q) > HZW'(MAX_HORIZON)) begin
			hz_eff = HZW'(MAX_HORIZON);
		end else begin
			hz_eff = HZW'(horizon_q);
		end
	end

	always_comb begin
		case (init_q)
			A_ONE: init_word = ONE32;
			A_MONE: init_word = MONE32;
			A_FOUR: init_word = ONE32 << 2;
			A_TWO: init_word = ONE32 << 1;
			A_D: init_word = step_distance_q[31] ? 32'h7FFF_FFFF : step_distance_q;
			A_CURV: init_word = ff_enable_q ? curv_q : 32'd0;
			A_Q00: init_word = w_cross_q[31] ? 32'h7FFF_FFFF : w_cross_q;
			A_Q11: init_word = w_heading_q[31] ? 32'h7FFF_FFFF : w_heading_q;
			A_Q22: init_word = w_steer_q[31] ? 32'h7FFF_FFFF : w_steer_q;
			A_R: begin
				if (w_rate_q == 32'd0) begin
					init_word = 32'd1;
				end else begin
					init_word = w_rate_q[31] ? 32'h7FFF_FFFF : w_rate_q;
				end
			end
			A_CTE: init_word = cte_q;
			A_HDG: init_word = hdg_q;
			A_PREV: init_word = prev_q;
			default: init_word = 32'd0;
		endcase
	end

	always_comb begin
		rnd = uop_q.sh30 ? ((prod_q + HALF30) >>> 30) : ((prod_q + HALF64) >>> FRAC_BITS);
		e_term = uop_q.use_acc ? acc_q : 64'(ope_q);
		sum = rnd + e_term + 64'(opf_q);
		sum_fit = fit32(sum);
		q_signed = neg_q ? (64'sd0 - $signed(64'(dvd_q))) : $signed(64'(dvd_q));
		div_fit = fit32(q_signed);
		trial = {rem_q, dvd_q[NUMW-1]};
		trial_ge = trial >= {1'b0, den_q};
		mag = opa_q[31] ? (33'd0 - {1'b1, opa_q}) : {1'b0, opa_q};
		den_sel = uop_q.wb_div ? wb_eff : opb_q;
	end

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = uop_q.dst;
		ram_wdata = sum_fit[31:0];
		case (state_q)
			S_INIT: begin
				ram_we = 1'b1;
				ram_waddr = init_q;
				ram_wdata = init_word;
			end
			S_SUM: ram_we = ~uop_q.no_fit;
			S_DIV_END: begin
				ram_we = 1'b1;
				ram_wdata = div_fit[31:0];
			end
			default: ;
		endcase
		case (k_q)
			3'd0: ram_raddr = uop_q.a;
			3'd1: ram_raddr = uop_q.b;
			3'd2: ram_raddr = uop_q.e;
			default: ram_raddr = uop_q.f;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (start) state_d = S_INIT;
			S_INIT: if (init_q == A_INIT_LAST) state_d = S_DECODE;
			S_DECODE: begin
				case (cur_uop.kind)
					K_MAC, K_DIV, K_LOOP: state_d = S_FETCH;
					K_CHKG: if (last_q < 32'sd1) state_d = S_FINISH;
					K_LAST: state_d = S_DECODE;
					default: state_d = S_FINISH;
				endcase
			end
			S_FETCH: begin
				if (k_q == 3'd4) begin
					state_d = (uop_q.kind == K_DIV) ? S_DIV_SETUP : S_MUL;
				end
			end
			S_MUL: state_d = S_SUM;
			S_SUM: state_d = S_DECODE;
			S_DIV_SETUP: state_d = S_DIV_RUN;
			S_DIV_RUN: if (dcnt_q == DCW'(0)) state_d = S_DIV_END;
			S_DIV_END: state_d = S_DECODE;
			S_FINISH: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
			init_q <= '0;
			k_q <= '0;
			step_q <= '0;
			dcnt_q <= '0;
			ok_q <= 1'b0;
			sat_q <= 1'b0;
			uop_q <= ctl(K_DONE);
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						pc_q <= '0;
						init_q <= '0;
						step_q <= '0;
						ok_q <= 1'b1;
						sat_q <= step_distance_q[31] | w_cross_q[31] | w_heading_q[31]
							| w_steer_q[31] | w_rate_q[31];
					end
				end
				S_INIT: init_q <= init_q + 1'b1;
				S_DECODE: begin
					uop_q <= cur_uop;
					k_q <= '0;
					case (cur_uop.kind)
						K_CHKG: begin
							if (last_q < 32'sd1) begin
								ok_q <= 1'b0;
							end else begin
								pc_q <= pc_q + 1'b1;
							end
						end
						K_LAST: begin
							if (HZW'(step_q + 1'b1) >= hz_eff) begin
								pc_q <= FINAL_PC;
							end else begin
								pc_q <= pc_q + 1'b1;
							end
						end
						// The loop-closing step also carries the last update of s.
						K_LOOP: step_q <= step_q + 1'b1;
						default: ;
					endcase
				end
				S_FETCH: k_q <= k_q + 1'b1;
				S_SUM: begin
					if (!uop_q.no_fit) begin
						sat_q <= sat_q | sum_fit[32];
					end
					pc_q <= (uop_q.kind == K_LOOP) ? LOOP_PC : pc_q + 1'b1;
				end
				S_DIV_SETUP: dcnt_q <= DCW'(NUMW - 1);
				S_DIV_RUN: dcnt_q <= dcnt_q - 1'b1;
				S_DIV_END: begin
					sat_q <= sat_q | div_fit[32];
					pc_q <= pc_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			cte_q <= cross_track_error;
			hdg_q <= heading_error;
			curv_q <= path_curvature;
			prev_q <= previous_steer;
		end
		if (state_q == S_FETCH) begin
			case (k_q)
				3'd1: opa_q <= $signed(ram_rdata);
				3'd2: opb_q <= $signed(ram_rdata);
				3'd3: ope_q <= $signed(ram_rdata);
				3'd4: opf_q <= $signed(ram_rdata);
				default: ;
			endcase
		end
		if (state_q == S_MUL) begin
			prod_q <= opa_q * opb_q;
		end
		if (state_q == S_SUM) begin
			acc_q <= sum;
			if (!uop_q.no_fit) begin
				last_q <= $signed(sum_fit[31:0]);
				if (uop_q.dst == A_DEL) del_q <= $signed(sum_fit[31:0]);
				if (uop_q.dst == A_CMD) cmd_q <= $signed(sum_fit[31:0]);
			end
		end
		if (state_q == S_DIV_SETUP) begin
			neg_q <= opa_q[31];
			den_q <= den_sel;
			rem_q <= '0;
			dvd_q <= (NUMW'(mag) << FRAC_BITS) + NUMW'(den_sel >> 1);
		end
		if (state_q == S_DIV_RUN) begin
			rem_q <= trial_ge ? 32'(trial - {1'b0, den_q}) : trial[31:0];
			dvd_q <= {dvd_q[NUMW-2:0], trial_ge};
		end
		if (state_q == S_DIV_END) begin
			last_q <= $signed(div_fit[31:0]);
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_FINISH);
	assign result_valid = done & ok_q & ~sat_q;
	assign steer_change = (ok_q & ~sat_q) ? del_q : 32'sd0;
	assign steer_command = (ok_q & ~sat_q) ? cmd_q : 32'sd0;

endmodule

`default_nettype wire

/* rtl/lmrs_ram.sv */
// ----------------------------------------------------------------------------
// Generic scratch RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lmrs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire
